[design/quadrature_encoder_with_button_assert.svh]
// Assertion macros shared by the checker modules of the encoder block.
`ifndef QUADRATURE_ENCODER_WITH_BUTTON_ASSERT_SVH
`define QUADRATURE_ENCODER_WITH_BUTTON_ASSERT_SVH

// The antecedent holding in a cycle requires the consequent in the same cycle.
`define QEB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder block: same-cycle property failed");

// The antecedent holding in a cycle requires the consequent in the next cycle.
`define QEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder block: next-cycle property failed");

`endif

[design/qeb_pkg.sv]
`default_nettype none

package qeb_pkg;

    localparam int CHECK_INTERVAL_TICKS_DEF = 10;
    localparam int DOUBLE_CLICK_TICKS_DEF = 600;
    localparam int HOLD_TICKS_DEF = 1200;
    localparam int ACCEL_MAX_DEF = 6400;

    localparam int ACCEL_RISE = 50;
    localparam int ACCEL_FALL = 2;

    localparam logic [2:0] BS_OPEN = 3'd0;
    localparam logic [2:0] BS_HELD = 3'd1;
    localparam logic [2:0] BS_RELEASED = 3'd2;
    localparam logic [2:0] BS_CLICKED = 3'd3;
    localparam logic [2:0] BS_DOUBLE = 3'd4;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] DEC_GRAY = 2'd0;
    localparam logic [1:0] DEC_FULL = 2'd1;
    localparam logic [1:0] DEC_HALF = 2'd2;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [2:0] CFG_ACTIVE_LEVEL = 3'd0;
    localparam logic [2:0] CFG_STEPS_PER_NOTCH = 3'd1;
    localparam logic [2:0] CFG_DECODER_MODE = 3'd2;
    localparam logic [2:0] CFG_ACCEL_ENABLE = 3'd3;
    localparam logic [2:0] CFG_DOUBLE_CLICK_ENABLE = 3'd4;
    localparam logic [2:0] CFG_BUTTON_PRESENT = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 3;

    localparam logic signed [1:0] FULL_TAB [16] = '{
        2'sd0, 2'sd1, -2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1,
        2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0
    };
    localparam logic signed [1:0] HALF_TAB [16] = '{
        2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1,
        2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0, -2'sd1, 2'sd0, 2'sd0
    };

    typedef struct packed {
        logic action;
        logic pin_a;
        logic pin_b;
        logic pin_button;
    } qeb_in_t;

    typedef struct packed {
        logic signed [5:0] step_value;
        logic [1:0]        direction;
        logic [2:0]        button_state;
    } qeb_out_t;

endpackage

`default_nettype wire

[design/quadrature_encoder_with_button.sv]
// Rotary encoder decoder with acceleration and push-button click detection.
// Input channel (in_valid/in_ready/in_data): a tick transfer carries the pin
// levels sampled once per millisecond and produces no result; a read transfer
// produces exactly one result on the output channel.
// Output channel (out_valid/out_ready/out_data): step value, direction and
// button state. A read result is registered, so it appears in the cycle after
// the read transfer.
// Throughput is one input transfer per cycle unless the receiver stalls; all
// state is updated by single pass logic between the input port and the state
// and result registers. The configuration port writes a register at any edge
// with cfg_we high and should only be used while the block is idle.
// Reset clears all counters, the step accumulator and the phase, sets the
// button state to open, restores the configuration defaults and empties the
// result register.
// When the receiver stalls, the pending result is held and in_ready drops
// until it is taken; a result taken in a cycle frees the register for a new
// transfer in that same cycle.
`default_nettype none

module quadrature_encoder_with_button #(
    parameter int CHECK_INTERVAL_TICKS = qeb_pkg::CHECK_INTERVAL_TICKS_DEF,
    parameter int DOUBLE_CLICK_TICKS = qeb_pkg::DOUBLE_CLICK_TICKS_DEF,
    parameter int HOLD_TICKS = qeb_pkg::HOLD_TICKS_DEF,
    parameter int ACCEL_MAX = qeb_pkg::ACCEL_MAX_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire qeb_pkg::qeb_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output qeb_pkg::qeb_out_t                    out_data,
    input  wire logic                            cfg_we,
    input  wire logic [qeb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [qeb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import qeb_pkg::*;

    localparam int WINDOW_RAW = DOUBLE_CLICK_TICKS / CHECK_INTERVAL_TICKS;
    localparam logic [7:0] WINDOW_LEN = 8'((WINDOW_RAW > 255) ? 255 : WINDOW_RAW);
    localparam logic [15:0] HOLD_LIMIT = 16'(HOLD_TICKS / CHECK_INTERVAL_TICKS);
    localparam logic [12:0] ACCEL_LIMIT = 13'(ACCEL_MAX - ACCEL_RISE);
    localparam logic [3:0] CHECK_LIMIT = 4'(CHECK_INTERVAL_TICKS);

    logic        active_level_reg;
    logic [2:0]  steps_per_notch_reg;
    logic [1:0]  decoder_mode_reg;
    logic        accel_enable_reg;
    logic        double_click_enable_reg;
    logic        button_present_reg;

    logic signed [15:0] step_acc_reg, step_acc_next;
    logic [3:0]         phase_reg, phase_next;
    logic [12:0]        accel_reg, accel_next;
    logic [2:0]         status_reg, status_next;
    logic [15:0]        press_reg, press_next;
    logic [7:0]         window_reg, window_next;
    logic [3:0]         interval_reg, interval_next;
    logic               out_valid_reg, out_valid_next;
    qeb_out_t           out_data_reg, out_data_next;

    logic               in_fire;
    logic               a_on, b_on, btn_on;
    logic [1:0]         gray_cur, gray_diff;
    logic [3:0]         tab_phase;
    logic signed [1:0]  delta;
    logic               moved;
    logic signed [16:0] acc_sum;
    logic [12:0]        accel_dec;
    logic [3:0]         interval_inc;
    logic [5:0]         mag_wide;
    logic signed [5:0]  mag;
    logic               above_thr;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    assign a_on = (in_data.pin_a == active_level_reg);
    assign b_on = (in_data.pin_b == active_level_reg);
    assign btn_on = (in_data.pin_button == active_level_reg);
    assign gray_cur = {a_on, a_on ^ b_on};
    assign gray_diff = phase_reg[1:0] - gray_cur;
    assign tab_phase = {phase_reg[1:0], a_on, b_on};
    assign acc_sum = 17'(step_acc_reg) + 17'(delta);
    assign accel_dec = (accel_reg >= 13'(ACCEL_FALL)) ? accel_reg - 13'(ACCEL_FALL) : '0;
    assign interval_inc = (interval_reg < 4'd15) ? interval_reg + 4'd1 : interval_reg;
    assign mag_wide = 6'd1 + (accel_enable_reg ? {1'b0, accel_reg[12:8]} : 6'd0);
    assign mag = (mag_wide > 6'd31) ? 6'sd31 : $signed(mag_wide);

    always_comb
    begin
        case (steps_per_notch_reg)
            3'd2: above_thr = (step_acc_reg >= 16'sd2);
            3'd4: above_thr = (step_acc_reg >= 16'sd4);
            default: above_thr = (step_acc_reg >= 16'sd1);
        endcase
    end

    always_comb
    begin
        delta = 2'sd0;
        moved = 1'b0;
        phase_next = phase_reg;
        case (decoder_mode_reg)
            DEC_GRAY:
            begin
                if (gray_diff[0])
                begin
                    phase_next = {2'b00, gray_cur};
                    delta = gray_diff[1] ? 2'sd1 : -2'sd1;
                    moved = 1'b1;
                end
            end
            DEC_FULL:
            begin
                phase_next = tab_phase;
                delta = FULL_TAB[tab_phase];
                moved = (delta != 2'sd0);
            end
            DEC_HALF:
            begin
                phase_next = tab_phase;
                delta = HALF_TAB[tab_phase];
                moved = (delta != 2'sd0);
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
        if (!in_fire || in_data.action != ACT_TICK)
        begin
            phase_next = phase_reg;
        end
    end

    always_comb
    begin
        step_acc_next = step_acc_reg;
        accel_next = accel_reg;
        status_next = status_reg;
        press_next = press_reg;
        window_next = window_reg;
        interval_next = interval_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next = out_data_reg;

        if (in_fire && in_data.action == ACT_TICK)
        begin
            if (moved)
            begin
                if (acc_sum[16] != acc_sum[15])
                begin
                    step_acc_next = acc_sum[16] ? -16'sd32768 : 16'sd32767;
                end
                else
                begin
                    step_acc_next = acc_sum[15:0];
                end
            end
            if (accel_enable_reg)
            begin
                accel_next = (moved && accel_dec <= ACCEL_LIMIT)
                           ? accel_dec + 13'(ACCEL_RISE) : accel_dec;
            end
            interval_next = interval_inc;
            if (button_present_reg && interval_inc >= CHECK_LIMIT)
            begin
                interval_next = 4'd0;
                if (btn_on)
                begin
                    press_next = (press_reg == 16'hFFFF) ? press_reg : press_reg + 16'd1;
                    if (press_next > HOLD_LIMIT)
                    begin
                        status_next = BS_HELD;
                    end
                end
                else
                begin
                    if (press_reg != 16'd0)
                    begin
                        if (status_reg == BS_HELD)
                        begin
                            status_next = BS_RELEASED;
                            window_next = 8'd0;
                        end
                        else if (window_reg > 8'd1)
                        begin
                            if (window_reg < WINDOW_LEN)
                            begin
                                status_next = BS_DOUBLE;
                                window_next = 8'd0;
                            end
                        end
                        else
                        begin
                            window_next = double_click_enable_reg ? WINDOW_LEN : 8'd1;
                        end
                    end
                    press_next = 16'd0;
                end
                if (window_next > 8'd0)
                begin
                    window_next = (window_next >= 8'd2) ? window_next - 8'd2 : 8'd0;
                    if (window_next == 8'd0)
                    begin
                        status_next = BS_CLICKED;
                    end
                end
            end
        end
        else if (in_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next.button_state = status_reg;
            out_data_next.step_value = 6'sd0;
            out_data_next.direction = DIR_NONE;
            if (status_reg != BS_HELD)
            begin
                status_next = BS_OPEN;
                case (steps_per_notch_reg)
                    3'd2: step_acc_next = {15'd0, step_acc_reg[0]};
                    3'd4: step_acc_next = {14'd0, step_acc_reg[1:0]};
                    default: step_acc_next = 16'sd0;
                endcase
                if (step_acc_reg[15])
                begin
                    out_data_next.step_value = -mag;
                    out_data_next.direction = DIR_DOWN;
                end
                else if (above_thr)
                begin
                    out_data_next.step_value = mag;
                    out_data_next.direction = DIR_UP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= 1'b0;
            steps_per_notch_reg <= 3'd4;
            decoder_mode_reg <= DEC_GRAY;
            accel_enable_reg <= 1'b1;
            double_click_enable_reg <= 1'b1;
            button_present_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                CFG_STEPS_PER_NOTCH: steps_per_notch_reg <= cfg_data[2:0];
                CFG_DECODER_MODE: decoder_mode_reg <= cfg_data[1:0];
                CFG_ACCEL_ENABLE: accel_enable_reg <= cfg_data[0];
                CFG_DOUBLE_CLICK_ENABLE: double_click_enable_reg <= cfg_data[0];
                CFG_BUTTON_PRESENT: button_present_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_acc_reg <= '0;
            phase_reg <= '0;
            accel_reg <= '0;
            status_reg <= BS_OPEN;
            press_reg <= '0;
            window_reg <= '0;
            interval_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_acc_reg <= step_acc_next;
            phase_reg <= phase_next;
            accel_reg <= accel_next;
            status_reg <= status_next;
            press_reg <= press_next;
            window_reg <= window_next;
            interval_reg <= interval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

[design/qeb_checker.sv]
`default_nettype none

`include "quadrature_encoder_with_button_assert.svh"

module qeb_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire qeb_pkg::qeb_in_t  in_data,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire qeb_pkg::qeb_out_t out_data
);
    import qeb_pkg::*;

    `QEB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `QEB_ASSERT_NEXT(a_read_gives_result, in_valid && in_ready && in_data.action == ACT_READ, out_valid)
    `QEB_ASSERT_NEXT(a_tick_no_result, in_valid && in_ready && in_data.action == ACT_TICK && !out_valid, !out_valid)
    `QEB_ASSERT_SAME(a_held_no_step, out_valid && out_data.button_state == BS_HELD, out_data.direction == DIR_NONE && out_data.step_value == 6'sd0)
    `QEB_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready)

endmodule

bind quadrature_encoder_with_button qeb_checker u_qeb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
);

`default_nettype wire

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import qeb_pkg::*;

    localparam int IDLE_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 150;
    localparam int HOLD_CHECKS = HOLD_TICKS_DEF / CHECK_INTERVAL_TICKS_DEF;
    localparam int WINDOW_CHECKS =
        (DOUBLE_CLICK_TICKS_DEF / CHECK_INTERVAL_TICKS_DEF > 255) ?
        255 : DOUBLE_CLICK_TICKS_DEF / CHECK_INTERVAL_TICKS_DEF;
    localparam logic [1:0] DEC_NONE = 2'd3;

    // Step tables as masks over the four-bit phase history.
    localparam logic [15:0] FULL_UP = 16'h4182;
    localparam logic [15:0] FULL_DOWN = 16'h2814;
    localparam logic [15:0] HALF_UP = 16'h0180;
    localparam logic [15:0] HALF_DOWN = 16'h2004;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    qeb_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    qeb_out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic m_active = 1'b0;
    logic [2:0] m_notch = 3'd4;
    logic [1:0] m_mode = DEC_GRAY;
    logic m_accel_en = 1'b1;
    logic m_dbl_en = 1'b1;
    logic m_btn_present = 1'b1;

    logic signed [15:0] m_count = '0;
    logic [3:0] m_phase = '0;
    logic [12:0] m_accel = '0;
    logic [2:0] m_button = BS_OPEN;
    logic [15:0] m_press = '0;
    logic [7:0] m_window = '0;
    logic [3:0] m_interval = '0;

    qeb_out_t expected_reports[$];
    qeb_out_t want;
    int mismatch_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;
    logic button_on = 1'b0;
    int shaft = 0;

    quadrature_encoder_with_button i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4ns clk = ~clk;

    function automatic int pick_pause();
        if ($urandom_range(0, 9) != 0)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic predict_transfer(input qeb_in_t item);
        logic a_on;
        logic b_on;
        logic pressed;
        int cur;
        int diff;
        int delta;
        int sum;
        int held_count;
        int mag;
        int thr;
        qeb_out_t reply;
        if (item.action == ACT_TICK)
        begin
            a_on = (item.pin_a == m_active);
            b_on = (item.pin_b == m_active);
            delta = 0;
            if (m_accel_en)
            begin
                m_accel = (m_accel >= 13'(ACCEL_FALL)) ? m_accel - 13'(ACCEL_FALL) : '0;
            end
            if (m_mode == DEC_GRAY)
            begin
                cur = (a_on ? 3 : 0) ^ (b_on ? 1 : 0);
                diff = (int'(m_phase) - cur) & 3;
                if ((diff & 1) != 0)
                begin
                    m_phase = 4'(cur);
                    delta = (diff & 2) - 1;
                end
            end
            else if (m_mode == DEC_FULL || m_mode == DEC_HALF)
            begin
                m_phase = {m_phase[1:0], a_on, b_on};
                if (m_mode == DEC_FULL)
                begin
                    delta = FULL_UP[m_phase] ? 1 : (FULL_DOWN[m_phase] ? -1 : 0);
                end
                else
                begin
                    delta = HALF_UP[m_phase] ? 1 : (HALF_DOWN[m_phase] ? -1 : 0);
                end
            end
            if (delta != 0)
            begin
                sum = int'(m_count) + delta;
                if (sum > 32767)
                begin
                    sum = 32767;
                end
                if (sum < -32768)
                begin
                    sum = -32768;
                end
                m_count = 16'(sum);
                if (m_accel_en && m_accel <= ACCEL_MAX_DEF - ACCEL_RISE)
                begin
                    m_accel = m_accel + 13'(ACCEL_RISE);
                end
            end
            if (m_interval < 4'd15)
            begin
                m_interval++;
            end
            if (m_btn_present && m_interval >= CHECK_INTERVAL_TICKS_DEF)
            begin
                m_interval = '0;
                pressed = (item.pin_button == m_active);
                if (pressed)
                begin
                    if (m_press != 16'hFFFF)
                    begin
                        m_press++;
                    end
                    if (m_press > HOLD_CHECKS)
                    begin
                        m_button = BS_HELD;
                    end
                end
                else
                begin
                    if (m_press != '0)
                    begin
                        if (m_button == BS_HELD)
                        begin
                            m_button = BS_RELEASED;
                            m_window = '0;
                        end
                        else if (m_window > 8'd1)
                        begin
                            if (m_window < WINDOW_CHECKS)
                            begin
                                m_button = BS_DOUBLE;
                                m_window = '0;
                            end
                        end
                        else
                        begin
                            m_window = m_dbl_en ? 8'(WINDOW_CHECKS) : 8'd1;
                        end
                    end
                    m_press = '0;
                end
                if (m_window != '0)
                begin
                    m_window = (m_window >= 8'd2) ? m_window - 8'd2 : '0;
                    if (m_window == '0)
                    begin
                        m_button = BS_CLICKED;
                    end
                end
            end
        end
        else
        begin
            reply.button_state = m_button;
            reply.step_value = '0;
            reply.direction = DIR_NONE;
            if (m_button != BS_HELD)
            begin
                m_button = BS_OPEN;
                held_count = int'(m_count);
                mag = 1 + (m_accel_en ? int'(m_accel >> 8) : 0);
                if (mag > 31)
                begin
                    mag = 31;
                end
                if (m_notch == 3'd2)
                begin
                    thr = 2;
                    m_count = 16'(held_count & 1);
                end
                else if (m_notch == 3'd4)
                begin
                    thr = 4;
                    m_count = 16'(held_count & 3);
                end
                else
                begin
                    thr = 1;
                    m_count = '0;
                end
                if (held_count < 0)
                begin
                    reply.step_value = 6'(-mag);
                    reply.direction = DIR_DOWN;
                end
                else if (held_count >= thr)
                begin
                    reply.step_value = 6'(mag);
                    reply.direction = DIR_UP;
                end
            end
            expected_reports.push_back(reply);
        end
    endtask

    task automatic send_item(input qeb_in_t item);
        int gap;
        logic taken;
        gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? pick_pause() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        predict_transfer(item);
        items_sent++;
    endtask

    task automatic sample_pins(input logic a_on, input logic b_on, input logic btn_on);
        qeb_in_t item;
        item.action = ACT_TICK;
        item.pin_a = a_on ? m_active : !m_active;
        item.pin_b = b_on ? m_active : !m_active;
        item.pin_button = btn_on ? m_active : !m_active;
        send_item(item);
    endtask

    task automatic turn(input int dir, input int n);
        repeat (n)
        begin
            shaft = (shaft + dir) & 3;
            sample_pins(shaft[1], shaft[1] ^ shaft[0], button_on);
        end
    endtask

    task automatic press(input int n);
        button_on = 1'b1;
        turn(0, n);
        button_on = 1'b0;
    endtask

    task automatic read_request();
        qeb_in_t item;
        item = 4'($urandom_range(0, 15));
        item.action = ACT_READ;
        send_item(item);
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic configure(input logic active, input logic [2:0] notch,
                             input logic [1:0] mode, input logic accel_en,
                             input logic dbl_en, input logic present);
        drain(4);
        write_reg(CFG_ACTIVE_LEVEL, {2'b00, active});
        write_reg(CFG_STEPS_PER_NOTCH, notch);
        write_reg(CFG_DECODER_MODE, {1'b0, mode});
        write_reg(CFG_ACCEL_ENABLE, {2'b00, accel_en});
        write_reg(CFG_DOUBLE_CLICK_ENABLE, {2'b00, dbl_en});
        write_reg(CFG_BUTTON_PRESENT, {2'b00, present});
        cfg_we <= 1'b0;
        m_active = active;
        m_notch = notch;
        m_mode = mode;
        m_accel_en = accel_en;
        m_dbl_en = dbl_en;
        m_btn_present = present;
    endtask

    task automatic test_directed();
        read_request();
        // The phase starts from zero whatever the pins show, so this is a step down.
        turn(-1, 1);
        read_request();
        turn(1, 8);
        read_request();
        turn(-1, 3);
        read_request();
        turn(0, 1);
        button_on = 1'b1;
        turn(2, 1);
        button_on = 1'b0;
        read_request();
        read_request();
    endtask

    task automatic test_decoders();
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int notch = 1; notch <= 4; notch++)
            begin
                configure(notch[0], notch[2:0], mode[1:0], 1'b1, 1'b1, 1'b1);
                turn(1, $urandom_range(1, 4));
                read_request();
                turn(-1, $urandom_range(1, 4));
                read_request();
                turn(2, 1);
                turn(1, 2);
                read_request();
                turn(-1, 1);
                read_request();
            end
        end
    endtask

    task automatic test_acceleration();
        configure(1'b1, 3'd1, DEC_FULL, 1'b1, 1'b1, 1'b1);
        repeat (9)
        begin
            turn(1, 16);
            read_request();
        end
        repeat (2)
        begin
            turn(-1, 8);
            read_request();
        end
        turn(0, 40);
        turn(1, 1);
        read_request();
        configure(1'b0, 3'd4, DEC_HALF, 1'b0, 1'b1, 1'b1);
        repeat (2)
        begin
            turn(1, 8);
            read_request();
        end
    endtask

    task automatic test_button();
        configure(1'b0, 3'd4, DEC_GRAY, 1'b1, 1'b1, 1'b1);
        press(15);
        turn(1, 4);
        turn(0, 320);
        read_request();
        read_request();
        press(15);
        turn(0, 50);
        press(15);
        turn(0, 15);
        read_request();
        read_request();
        configure(1'b0, 3'd4, DEC_GRAY, 1'b1, 1'b0, 1'b1);
        press(15);
        turn(0, 15);
        read_request();
        configure(1'b1, 3'd2, DEC_GRAY, 1'b1, 1'b1, 1'b0);
        press(12);
        turn(0, 12);
        read_request();
        configure(1'b1, 3'd2, DEC_GRAY, 1'b1, 1'b0, 1'b1);
        press(20);
        turn(0, 15);
        read_request();
    endtask

    task automatic test_random();
        int start;
        int choice;
        bit paused;
        start = items_sent;
        paused = 1'b0;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                configure(1'($urandom_range(0, 1)), 3'($urandom_range(1, 4)),
                          ($urandom_range(0, 7) == 0) ? DEC_NONE : 2'($urandom_range(0, 2)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 5) != 0);
            end
            tx_gaps_on = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            if (!paused && items_sent - start >= RANDOM_ITEMS / 2)
            begin
                drain(2);
                paused = 1'b1;
            end
            choice = $urandom_range(0, 19);
            if (choice < 11)
            begin
                turn($urandom_range(0, 1) ? 1 : -1, $urandom_range(1, 12));
            end
            else if (choice < 13)
            begin
                turn(0, $urandom_range(1, 10));
            end
            else if (choice < 15)
            begin
                press($urandom_range(10, 40));
                if ($urandom_range(0, 1) == 0)
                begin
                    turn(0, $urandom_range(5, 60));
                    press($urandom_range(10, 25));
                end
            end
            else if (choice < 17)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    shaft = $urandom_range(0, 3);
                    sample_pins(shaft[1], shaft[1] ^ shaft[0], 1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 2)) read_request();
            end
            if ($urandom_range(0, 2) == 0)
            begin
                read_request();
            end
        end
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (rx_stalls_on && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left <= pick_pause() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Sampled at the falling edge, where everything seen holds until the next transfer edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("result %h arrived with no read pending", out_data));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (out_data.step_value !== want.step_value)
                begin
                    report_mismatch($sformatf("step_value %0d, expected %0d",
                                              $signed(out_data.step_value),
                                              $signed(want.step_value)));
                end
                if (out_data.direction !== want.direction)
                begin
                    report_mismatch($sformatf("direction %0d, expected %0d",
                                              out_data.direction, want.direction));
                end
                if (out_data.button_state !== want.button_state)
                begin
                    report_mismatch($sformatf("button_state %0d, expected %0d",
                                              out_data.button_state, want.button_state));
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_decoders();
        test_acceleration();
        test_button();
        test_random();
        drain(8);
        if (mismatch_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
